// ===== hw/rtl/utf8_text_validator_defines.svh =====
// assertion macros shared by the utf8 text validator checker
// needs nothing else; include by bare file name
`ifndef UTF8_TEXT_VALIDATOR_DEFINES_SVH
`define UTF8_TEXT_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UTV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UTV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/utv_pkg.sv =====
// types and decode functions for the utf8 text validator
// standalone package, no dependencies
`default_nettype none

package utv_pkg;

   // allowed range for the next continuation word
   typedef enum logic [2:0] {
      RC_80_BF = 3'd0,
      RC_A0_BF = 3'd1,
      RC_80_9F = 3'd2,
      RC_90_BF = 3'd3,
      RC_80_8F = 3'd4
   } range_class_type;

   // decoded lead word
   typedef struct packed {
      logic            ok;
      logic [1:0]      need;
      range_class_type cls;
   } lead_info_type;

   // continuation word check against the current range class
   function automatic logic cont_ok(input logic [7:0] b, input range_class_type cls);
      logic r;
      case (cls)
         RC_A0_BF: r = (b >= 8'ha0) && (b <= 8'hbf);
         RC_80_9F: r = (b >= 8'h80) && (b <= 8'h9f);
         RC_90_BF: r = (b >= 8'h90) && (b <= 8'hbf);
         RC_80_8F: r = (b >= 8'h80) && (b <= 8'h8f);
         default:  r = (b >= 8'h80) && (b <= 8'hbf);
      endcase
      return r;
   endfunction

   // lead word decode: length and first continuation range
   function automatic lead_info_type lead_decode(input logic [7:0] c);
      lead_info_type li;
      li.ok   = 1'b1;
      li.need = 2'd0;
      li.cls  = RC_80_BF;
      unique case (c) inside
         [8'h20:8'h7f], 8'h09, 8'h0a, 8'h0d: li.need = 2'd0;
         [8'hc2:8'hdf]:                      li.need = 2'd1;
         8'he0: begin
            li.need = 2'd2;
            li.cls  = RC_A0_BF;
         end
         [8'he1:8'hec], 8'hee, 8'hef:        li.need = 2'd2;
         8'hed: begin
            li.need = 2'd2;
            li.cls  = RC_80_9F;
         end
         8'hf0: begin
            li.need = 2'd3;
            li.cls  = RC_90_BF;
         end
         [8'hf1:8'hf3]:                      li.need = 2'd3;
         8'hf4: begin
            li.need = 2'd3;
            li.cls  = RC_80_8F;
         end
         default:                            li.ok = 1'b0;
      endcase
      return li;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_text_validator.sv =====
// UTF-8 text validator: checks a byte stream one word per clock and flags
// the first failing word of each message. Throughput is one word per clock,
// back to back, while rsp_tready stays high. A word goes from req acceptance
// through the input register and then the result register to rsp. The rate
// is set by the decode loop through the sequence state (continuations left,
// next range class, sticky error), which updates as each word moves from the
// input register to the result register. The result register lets a new word
// enter while a finished result waits to be taken.
// Depends on utv_pkg.
`default_nettype none

module utf8_text_validator (
   input  wire logic       clock,
   input  wire logic       reset,
   // input stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // last_byte
   // result stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [0] valid_so_far, [1] error_here, [7:2] zero
   output logic            rsp_tlast    // message_end
);

   // input register
   logic                    in_valid_ff;
   logic [7:0]              in_data_ff;
   logic                    in_last_ff;

   // sequence state
   logic [1:0]              cont_left_ff, cont_left_in;
   utv_pkg::range_class_type range_ff, range_in;
   logic                    error_seen_ff, error_seen_in;

   // result register
   logic                    out_valid_ff;
   logic                    out_last_ff;
   logic                    out_ok_ff, out_ok_in;
   logic                    out_err_ff, out_err_in;

   logic                    advance;
   logic                    err_here;
   utv_pkg::lead_info_type  lead;

   // move a word into the result register when it is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // decode and next sequence state
   always_comb begin
      lead          = utv_pkg::lead_decode(in_data_ff);
      err_here      = 1'b0;
      cont_left_in  = cont_left_ff;
      range_in      = range_ff;
      error_seen_in = error_seen_ff;
      if (!error_seen_ff) begin
         if (cont_left_ff != 2'd0) begin
            if (utv_pkg::cont_ok(in_data_ff, range_ff)) begin
               cont_left_in = cont_left_ff - 2'd1;
               range_in     = utv_pkg::RC_80_BF;
            end else begin
               err_here = 1'b1;
            end
         end else begin
            if (lead.ok) begin
               cont_left_in = lead.need;
               range_in     = lead.cls;
            end else begin
               err_here = 1'b1;
            end
         end
         // unfinished sequence at message end
         if (!err_here && in_last_ff && (cont_left_in != 2'd0)) begin
            err_here = 1'b1;
         end
         if (err_here) begin
            error_seen_in = 1'b1;
         end
      end
      out_ok_in  = !error_seen_in;
      out_err_in = err_here;
      // fresh state for the next message
      if (in_last_ff) begin
         cont_left_in  = 2'd0;
         range_in      = utv_pkg::RC_80_BF;
         error_seen_in = 1'b0;
      end
   end

   // sequence state register
   always_ff @(posedge clock) begin
      if (reset) begin
         cont_left_ff  <= 2'd0;
         range_ff      <= utv_pkg::RC_80_BF;
         error_seen_ff <= 1'b0;
      end else if (advance) begin
         cont_left_ff  <= cont_left_in;
         range_ff      <= range_in;
         error_seen_ff <= error_seen_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_last_ff <= in_last_ff;
         out_ok_ff   <= out_ok_in;
         out_err_ff  <= out_err_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'd0, out_err_ff, out_ok_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/utv_checker.sv =====
// port-level checker for the utf8 text validator, bound to the top level
// depends on utf8_text_validator_defines.svh and utf8_text_validator
`default_nettype none

`include "utf8_text_validator_defines.svh"

module utv_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // a stalled result holds its word
   `UTV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")

   // the failing word never reports the message as still valid
   `UTV_ASSERT_NOW(a_err_not_ok, clock, reset, rsp_tvalid && rsp_tdata[1],
      !rsp_tdata[0], "error_here with valid_so_far set")

   // padding bits stay zero
   `UTV_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid,
      rsp_tdata[7:2] == 6'd0, "nonzero rsp padding")

   // an empty result side never back-pressures the input
   `UTV_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid,
      req_tready, "req_tready low with result register empty")

endmodule

bind utf8_text_validator utv_port_checker u_utv_port_checker (.*);

`default_nettype wire
